### sv/bsee_pkg.sv
// ----------------------------------------------------------------------------
// bsee_pkg
// shared types and sequencer codes for the bubble sort unit
// ----------------------------------------------------------------------------
`default_nettype none

package bsee_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned STATE_W = 3;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [STATE_W-1:0]        t_state;

    // sequencer codes
    localparam t_state S_FILL  = 3'd0;  // collecting a batch
    localparam t_state S_PREP  = 3'd1;  // pass start, read entry 0
    localparam t_state S_READ1 = 3'd2;  // load carry, read entry 1
    localparam t_state S_CMP   = 3'd3;  // compare carry with next entry
    localparam t_state S_WEND  = 3'd4;  // write carry at pass end
    localparam t_state S_OUT   = 3'd5;  // stream the sorted batch

endpackage

`default_nettype wire

### sv/bsee_ram.sv
// ----------------------------------------------------------------------------
// bsee_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module bsee_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### sv/bubble_sort_early_exit_unit.sv
// ----------------------------------------------------------------------------
// bubble_sort_early_exit_unit
// batch sorter: collects signed values, bubble sorts them in a ram, streams
// them out smallest first
// ----------------------------------------------------------------------------
// usage
//   input transaction: start high while busy is low takes i_value / i_last.
//   a batch ends on an element with i_last set, or when DEPTH elements are
//   stored; in the latter case the following elements are dropped up to and
//   including the next one marked last, with no result.
//   result transactions: one per stored element, each shown for one cycle
//   with o_strobe high, ascending order, o_final_res on the last one. the
//   receiver cannot stall, so results are never held.
// sequence, for a batch of n elements
//   collecting accepts one element per cycle (busy stays low meanwhile).
//   each bubble pass over entries 0..e runs on the single compare unit fed
//   by the ram read port; passes shrink by one and stop after a pass with no
//   swap or after the pass over entries 0..1; a single element is not sorted.
//   streaming then reads entries 0..n-1 in order once the last pass end is
//   written.
// reset
//   synchronous active low reset empties the batch and returns to collecting;
//   ram contents are not cleared, only written entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module bubble_sort_early_exit_unit #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire bsee_pkg::t_value i_value,
    input  wire logic             i_last,
    output logic                  o_strobe,
    output bsee_pkg::t_value      o_sorted_value,
    output logic                  o_final_res
);

    import bsee_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_M1 = CW'(DEPTH - 1);

    // control state
    t_state        r_state,    n_state;
    logic [CW-1:0] r_fill,     n_fill;      // elements stored so far
    logic [AW-1:0] r_pass_end, n_pass_end;  // last index of current pass
    logic [AW-1:0] r_pos,      n_pos;       // index of entry arriving from ram
    logic [AW-1:0] r_last_idx, n_last_idx;  // index of final element of batch
    logic [AW-1:0] r_out_idx,  n_out_idx;   // next entry to read for output
    logic          r_swap,     n_swap;      // swap seen in current pass
    logic          r_discard,  n_discard;   // dropping rest of overfull batch
    logic          r_pend,     n_pend;      // ram data is a result this cycle
    logic          r_pend_last, n_pend_last;

    // payload
    t_value r_carry, n_carry;  // largest value met so far in the pass

    // ram port signals
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_value        wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_value        rd_data;

    logic accept;
    logic gt;

    bsee_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign busy   = (r_state != S_FILL);
    assign accept = start && !busy;

    // carry moves up only when strictly greater, so ties keep their order
    assign gt = (r_carry > rd_data);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_pass_end  = r_pass_end;
        n_pos       = r_pos;
        n_last_idx  = r_last_idx;
        n_out_idx   = r_out_idx;
        n_swap      = r_swap;
        n_discard   = r_discard;
        n_pend      = 1'b0;
        n_pend_last = 1'b0;
        n_carry     = r_carry;
        wr_en       = 1'b0;
        wr_addr     = r_fill[AW-1:0];
        wr_data     = i_value;
        rd_en       = 1'b0;
        rd_addr     = r_out_idx;

        case (r_state)
            S_FILL: begin
                if (accept) begin
                    if (r_discard) begin
                        // overfull batch tail, no result
                        if (i_last) begin
                            n_discard = 1'b0;
                        end
                    end else begin
                        wr_en = 1'b1;
                        if (i_last || (r_fill == FULL_M1)) begin
                            // batch complete: n = r_fill + 1 elements
                            n_discard  = !i_last;
                            n_last_idx = r_fill[AW-1:0];
                            n_pass_end = r_fill[AW-1:0];
                            n_out_idx  = '0;
                            n_fill     = '0;
                            if (r_fill == '0) begin
                                n_state = S_OUT;
                            end else begin
                                n_state = S_PREP;
                            end
                        end else begin
                            n_fill = r_fill + CW'(1);
                        end
                    end
                end
            end
            S_PREP: begin
                rd_en   = 1'b1;
                rd_addr = '0;
                n_swap  = 1'b0;
                n_state = S_READ1;
            end
            S_READ1: begin
                n_carry = rd_data;
                rd_en   = 1'b1;
                rd_addr = AW'(1);
                n_pos   = AW'(1);
                n_state = S_CMP;
            end
            S_CMP: begin
                // settle entry r_pos - 1 and keep the larger value moving
                wr_en   = 1'b1;
                wr_addr = r_pos - AW'(1);
                wr_data = gt ? rd_data : r_carry;
                n_carry = gt ? r_carry : rd_data;
                n_swap  = r_swap || gt;
                if (r_pos == r_pass_end) begin
                    n_state = S_WEND;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_pos + AW'(1);
                    n_pos   = r_pos + AW'(1);
                end
            end
            S_WEND: begin
                wr_en   = 1'b1;
                wr_addr = r_pass_end;
                wr_data = r_carry;
                // early exit after a pass with no swap, or after the pass over entries 0..1
                if (!r_swap || (r_pass_end <= AW'(1))) begin
                    n_state = S_OUT;
                end else begin
                    n_pass_end = r_pass_end - AW'(1);
                    n_state    = S_PREP;
                end
            end
            S_OUT: begin
                rd_en       = 1'b1;
                rd_addr     = r_out_idx;
                n_pend      = 1'b1;
                n_pend_last = (r_out_idx == r_last_idx);
                if (r_out_idx == r_last_idx) begin
                    // last result shows next cycle while collecting resumes
                    n_state = S_FILL;
                end else begin
                    n_out_idx = r_out_idx + AW'(1);
                end
            end
            default: begin
                n_state = S_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_fill      <= '0;
            r_pass_end  <= '0;
            r_pos       <= '0;
            r_last_idx  <= '0;
            r_out_idx   <= '0;
            r_swap      <= 1'b0;
            r_discard   <= 1'b0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_pass_end  <= n_pass_end;
            r_pos       <= n_pos;
            r_last_idx  <= n_last_idx;
            r_out_idx   <= n_out_idx;
            r_swap      <= n_swap;
            r_discard   <= n_discard;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
    end

    // result comes straight from the ram read register
    assign o_strobe       = r_pend;
    assign o_sorted_value = rd_data;
    assign o_final_res    = r_pend_last;

    // results only follow an output read
    a_strobe_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) == S_OUT))
        else $error("result strobe without output read");

    a_final_marks_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_final_res |-> o_strobe)
        else $error("final flag outside a result");

    a_cmp_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ((r_pos != '0) && (r_pos <= r_pass_end)))
        else $error("compare position out of pass range");

    a_wend_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WEND) |=> ((r_state == S_PREP) || (r_state == S_OUT)))
        else $error("pass end not followed by new pass or output");

    a_pass_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_PREP) && ($past(r_state) == S_WEND))
            |-> (r_pass_end == $past(r_pass_end) - AW'(1)))
        else $error("pass end did not shrink by one");

endmodule

`default_nettype wire

### verif/bsee_checker.sv
// ----------------------------------------------------------------------------
// bsee_checker
// watches the element and result channels of the bubble sort unit, predicts
// each sorted batch and compares the streamed results in order
// ----------------------------------------------------------------------------
`default_nettype none

module bsee_checker #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic             i_busy,
    input  wire bsee_pkg::t_value i_value,
    input  wire logic             i_last,
    input  wire logic             i_strobe,
    input  wire bsee_pkg::t_value i_sorted_value,
    input  wire logic             i_final_res,
    output int unsigned           o_fail_count,
    output int unsigned           o_pending
);

    import bsee_pkg::*;

    typedef struct packed {
        t_value value;
        logic   final_res;
    } t_sorted_entry;

    t_value        batch_q[$];
    bit            dropping;
    t_sorted_entry sorted_q[$];
    int unsigned   fail_count;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fail_count   = 0;
        dropping     = 1'b0;
    end

    // bubble sort with early exit, then queue one expected result per element
    task automatic sort_and_queue();
        t_value        work[DEPTH];
        int unsigned   n;
        int unsigned   pass_limit;
        bit            swapped;
        t_value        tmp;
        t_sorted_entry entry;
        n = batch_q.size();
        for (int k = 0; k < n; k++) begin
            work[k] = batch_q[k];
        end
        if (n >= 2) begin
            pass_limit = n - 1;
            forever begin
                swapped = 1'b0;
                for (int k = 0; k < pass_limit; k++) begin
                    if (work[k] > work[k+1]) begin
                        tmp       = work[k];
                        work[k]   = work[k+1];
                        work[k+1] = tmp;
                        swapped   = 1'b1;
                    end
                end
                if (!swapped || pass_limit <= 1) break;
                pass_limit--;
            end
        end
        for (int k = 0; k < n; k++) begin
            entry.value     = work[k];
            entry.final_res = (k + 1 == n);
            sorted_q.push_back(entry);
        end
        batch_q.delete();
    endtask

    task automatic take_element(input t_value value, input logic last);
        if (dropping) begin
            if (last) dropping = 1'b0;
            return;
        end
        if (batch_q.size() < DEPTH) batch_q.push_back(value);
        if (!last && batch_q.size() < DEPTH) return;
        if (!last) dropping = 1'b1;
        sort_and_queue();
    endtask

    task automatic check_result(input t_value value, input logic final_res);
        t_sorted_entry want;
        if (sorted_q.size() == 0) begin
            if (fail_count < 10)
                $display("unexpected result: value %0d final %0b", value, final_res);
            fail_count++;
            return;
        end
        want = sorted_q.pop_front();
        if (want.value !== value || want.final_res !== final_res) begin
            if (fail_count < 10)
                $display("mismatch: expected value %0d final %0b, got value %0d final %0b",
                         want.value, want.final_res, value, final_res);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            batch_q.delete();
            sorted_q.delete();
            dropping = 1'b0;
        end else begin
            if (i_start && !i_busy) take_element(i_value, i_last);
            if (i_strobe) check_result(i_sorted_value, i_final_res);
        end
        o_fail_count <= fail_count;
        o_pending    <= sorted_q.size();
    end

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives batches of signed values into the bubble sort unit in random bursts
// and gives the verdict from the checker's failure count
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import bsee_pkg::*;

    localparam int unsigned DEPTH        = 16;
    localparam int unsigned TARGET_ITEMS = 250;
    localparam int unsigned TAIL_CYCLES  = 300;

    // shape of one random batch
    typedef enum int unsigned {
        BATCH_SHORT,
        BATCH_FULL,
        BATCH_OVERFLOW
    } t_batch_kind;

    localparam t_value VALUE_MIN = 32'sh8000_0000;
    localparam t_value VALUE_MAX = 32'sh7fff_ffff;

    // all block inputs known from time zero
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    t_value      i_value = '0;
    logic        i_last  = 1'b0;
    logic        busy;
    logic        o_strobe;
    t_value      o_sorted_value;
    logic        o_final_res;

    int unsigned fail_count;
    int unsigned pending;

    // sender pacing state
    int unsigned burst_left = 0;
    int unsigned stored_items = 0;

    bubble_sort_early_exit_unit #(
        .DEPTH          (DEPTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (i_value),
        .i_last         (i_last),
        .o_strobe       (o_strobe),
        .o_sorted_value (o_sorted_value),
        .o_final_res    (o_final_res)
    );

    bsee_checker #(
        .DEPTH          (DEPTH)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_value        (i_value),
        .i_last         (i_last),
        .i_strobe       (o_strobe),
        .i_sorted_value (o_sorted_value),
        .i_final_res    (o_final_res),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #2000000;
        $display("[bubble_sort_early_exit_unit] ERROR");
        $finish;
    end

    // mix of full-range values, small values for ties and the extremes
    function automatic t_value pick_value();
        case ($urandom_range(0, 5))
            0: pick_value = t_value'(int'($urandom_range(0, 8)) - 4);
            1: begin
                case ($urandom_range(0, 3))
                    0:       pick_value = VALUE_MIN;
                    1:       pick_value = VALUE_MAX;
                    2:       pick_value = '1;
                    default: pick_value = '0;
                endcase
            end
            default: pick_value = t_value'($urandom);
        endcase
    endfunction

    // one input transaction; start stays high across back-to-back transactions
    // and is only lowered when a gap follows
    task automatic send_element(input t_value value, input logic last);
        int unsigned gap;
        start   <= 1'b1;
        i_value <= value;
        i_last  <= last;
        // busy read here is its value before this edge, so this is the accept
        do @(posedge i_clk); while (busy);
        if (burst_left == 0) begin
            // long bursts give stretches with no idling at all
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(0, 3);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // a batch of n stored elements, last on the final one
    task automatic send_batch(input t_value vals[$]);
        foreach (vals[k]) send_element(vals[k], k == vals.size() - 1);
        stored_items += vals.size();
    endtask

    // fills the store without last, then items that the block drops
    task automatic send_overflow();
        int unsigned extra;
        for (int k = 0; k < DEPTH; k++) send_element(pick_value(), 1'b0);
        stored_items += DEPTH;
        extra = $urandom_range(0, 3);
        for (int k = 0; k < extra; k++) send_element(pick_value(), 1'b0);
        // ends the dropped run, no result expected
        send_element(pick_value(), 1'b1);
    endtask

    initial begin
        t_value      vals[$];
        t_batch_kind kind;
        int unsigned batch_idx;
        int unsigned n;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single elements at both extremes, a reversed extreme pair,
        // ties, already sorted, reversed with mixed signs
        send_batch('{VALUE_MIN});
        send_batch('{VALUE_MAX});
        send_batch('{VALUE_MAX, VALUE_MIN});
        send_batch('{32'sd7, 32'sd7, 32'sd7});
        send_batch('{-32'sd3, -32'sd1, 32'sd0, 32'sd5});
        send_batch('{VALUE_MAX, 32'sd1, 32'sd0, -32'sd1, VALUE_MIN});
        send_batch('{32'sd0, -32'sd1});

        // random batches; the first two force an exactly full store and an
        // overfull one
        batch_idx = 0;
        while (stored_items < TARGET_ITEMS) begin
            if (batch_idx == 0)
                kind = BATCH_FULL;
            else if (batch_idx == 1)
                kind = BATCH_OVERFLOW;
            else begin
                case ($urandom_range(0, 11))
                    0:       kind = BATCH_OVERFLOW;
                    1:       kind = BATCH_FULL;
                    default: kind = BATCH_SHORT;
                endcase
            end
            batch_idx++;
            case (kind)
                BATCH_OVERFLOW: send_overflow();
                default: begin
                    if (kind == BATCH_FULL)
                        n = DEPTH;
                    else if ($urandom_range(0, 3) == 0)
                        n = $urandom_range(2, DEPTH);
                    else
                        n = $urandom_range(1, 6);
                    vals.delete();
                    for (int k = 0; k < n; k++) vals.push_back(pick_value());
                    send_batch(vals);
                end
            endcase
        end
        start <= 1'b0;

        // drain expected results, then watch for stray ones
        do @(posedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("[bubble_sort_early_exit_unit] OK");
        end else begin
            $display("[bubble_sort_early_exit_unit] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

### bubble_sort_early_exit_unit.f
sv/bsee_pkg.sv
sv/bsee_ram.sv
sv/bubble_sort_early_exit_unit.sv
verif/bsee_checker.sv
verif/tb.sv
